/* rtl/sjfk_pkg.sv */
// Shared constants, types and helpers for the six-joint forward kinematics core.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sjfk_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int IN_W         = 16;
  localparam int REG_W        = 18;
  localparam int REG_COUNT    = 8;
  localparam int REG_IDX_W    = 3;
  localparam int OUT_ROT_W    = 18;
  localparam int OUT_POS_W    = 20;
  localparam int JOINTS       = 6;
  localparam int LINKS        = 5;
  localparam int TRIG_W       = FRAC_BITS + 2;
  localparam int ROT_W        = FRAC_BITS + 8;
  localparam int POS_W        = FRAC_BITS + 16;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int LANE_DEPTH   = CORDIC_STEPS + 2;
  localparam int CHAIN_DEPTH  = 2 * LINKS;
  localparam int PIPE_DEPTH   = LANE_DEPTH + CHAIN_DEPTH;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sh026DD3B6A;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_HEIGHT,
    REG_UPPER_ARM,
    REG_FOREARM,
    REG_ELBOW_OFFSET,
    REG_WRIST_ONE,
    REG_WRIST_TWO,
    REG_WRIST_THREE,
    REG_TOOL
  } reg_idx_t;

  localparam logic signed [REG_W-1:0] RST_BASE_HEIGHT  = 18'sd10650;
  localparam logic signed [REG_W-1:0] RST_UPPER_ARM    = -18'sd27853;
  localparam logic signed [REG_W-1:0] RST_FOREARM      = -18'sd25703;
  localparam logic signed [REG_W-1:0] RST_ELBOW_OFFSET = 18'sd0;
  localparam logic signed [REG_W-1:0] RST_WRIST_ONE    = 18'sd8736;
  localparam logic signed [REG_W-1:0] RST_WRIST_TWO    = 18'sd0;
  localparam logic signed [REG_W-1:0] RST_WRIST_THREE  = 18'sd0;
  localparam logic signed [REG_W-1:0] RST_TOOL         = 18'sd6527;

  typedef enum logic [2:0] {
    JK_SHOULDER,
    JK_ELBOW,
    JK_WRIST_ONE,
    JK_WRIST_TWO,
    JK_WRIST_THREE
  } joint_kind_t;

  localparam joint_kind_t LINK_KIND [LINKS] = '{
    JK_SHOULDER, JK_ELBOW, JK_WRIST_ONE, JK_WRIST_TWO, JK_WRIST_THREE
  };

  typedef logic [REG_COUNT-1:0][REG_W-1:0] offs_t;

  typedef struct packed {
    logic [JOINTS-1:0][TRIG_W-1:0] c;
    logic [JOINTS-1:0][TRIG_W-1:0] s;
  } trig_t;

  typedef struct packed {
    logic [8:0][ROT_W-1:0] r;
    logic [2:0][POS_W-1:0] p;
  } pose_t;

  localparam logic signed [ROT_W-1:0] ROT_ONE  = ROT_W'(1) << FRAC_BITS;
  localparam logic signed [POS_W-1:0] POS_HIGH = POS_W'(524287);
  localparam logic signed [POS_W-1:0] POS_LOW  = -POS_W'(524288);

  function automatic logic [OUT_ROT_W-1:0] clamp_rot(input logic signed [ROT_W-1:0] v);
    logic signed [ROT_W-1:0] t;
    t = (v > ROT_ONE) ? ROT_ONE : ((v < -ROT_ONE) ? -ROT_ONE : v);
    return t[OUT_ROT_W-1:0];
  endfunction

  function automatic logic [OUT_POS_W-1:0] clamp_pos(input logic signed [POS_W-1:0] v);
    logic signed [POS_W-1:0] t;
    t = (v > POS_HIGH) ? POS_HIGH : ((v < POS_LOW) ? POS_LOW : v);
    return t[OUT_POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/sjfk_cordic_lane.sv */
// One sine/cosine lane: quadrant fold, 30 pipelined CORDIC rotations, round and clamp.
// Depends on sjfk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjfk_cordic_lane import sjfk_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic [IN_W-1:0]          angle,
  output logic signed [TRIG_W-1:0] cos_out,
  output logic signed [TRIG_W-1:0] sin_out
);

  localparam int RSH = 30 - FRAC_BITS;
  localparam logic signed [CORDIC_W-1:0] RHALF = CORDIC_W'(1) << (RSH - 1);
  localparam logic signed [CORDIC_W-1:0] C_ONE = CORDIC_W'(1) << FRAC_BITS;

  logic [31:0] th_full, th_sum, th_fold;
  logic        fold;

  logic signed [CORDIC_W-1:0] x [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] y [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0] z [CORDIC_STEPS+1];
  logic                       neg [CORDIC_STEPS+1];

  logic signed [CORDIC_W-1:0] xr, yr, xc, yc;

  always_comb begin
    th_full = 32'({{(32-IN_W){1'b0}}, angle} << (32 - ANGLE_BITS));
    th_sum  = th_full + 32'h40000000;
    fold    = th_sum[31];
    th_fold = {th_full[31] ^ fold, th_full[30:0]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]   <= CORDIC_X0;
      y[0]   <= '0;
      z[0]   <= CORDIC_W'($signed(th_fold));
      neg[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z[i][CORDIC_W-1]) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - $signed(CORDIC_W'(ATAN_TURN[i]));
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + $signed(CORDIC_W'(ATAN_TURN[i]));
        end
        neg[i+1] <= neg[i];
      end
    end
  end

  always_comb begin
    xr = (x[CORDIC_STEPS] + RHALF) >>> RSH;
    yr = (y[CORDIC_STEPS] + RHALF) >>> RSH;
    xc = (xr > C_ONE) ? C_ONE : ((xr < -C_ONE) ? -C_ONE : xr);
    yc = (yr > C_ONE) ? C_ONE : ((yr < -C_ONE) ? -C_ONE : yr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_out <= TRIG_W'(neg[CORDIC_STEPS] ? -xc : xc);
      sin_out <= TRIG_W'(neg[CORDIC_STEPS] ? -yc : yc);
    end
  end

endmodule

`default_nettype wire

/* rtl/sjfk_chain_stage.sv */
// One link of the transform chain: pose times link transform in two registered steps.
// Depends on sjfk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjfk_chain_stage import sjfk_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  joint_kind_t kind,
  input  pose_t       pose_in,
  input  trig_t       trig_in,
  input  offs_t       offs,
  output pose_t       pose_out,
  output trig_t       trig_out
);

  localparam int PR_W = ROT_W + TRIG_W;
  localparam int PP_W = ROT_W + REG_W;
  localparam int SR_W = PR_W + 2;
  localparam int SP_W = PP_W + 2;
  localparam logic signed [SR_W-1:0] HALF_R = SR_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SP_W-1:0] HALF_P = SP_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [TRIG_W-1:0] T_ONE = TRIG_W'(1) << FRAC_BITS;

  logic [2:0]                 jsel;
  logic signed [TRIG_W-1:0]   c, s;
  logic signed [TRIG_W-1:0]   tr [3][3];
  logic signed [REG_W-1:0]    tp [3];
  logic signed [ROT_W-1:0]    mr [3][3];

  logic signed [PR_W-1:0]     pr [3][3][3];
  logic signed [PP_W-1:0]     pp [3][3];
  logic [2:0][POS_W-1:0]      mp_q;
  trig_t                      trig_a;

  logic signed [SR_W-1:0]     sr [3][3];
  logic signed [SP_W-1:0]     sp [3];
  pose_t                      pose_next;

  always_comb begin
    case (kind)
      JK_SHOULDER:    jsel = 3'd1;
      JK_ELBOW:       jsel = 3'd2;
      JK_WRIST_ONE:   jsel = 3'd3;
      JK_WRIST_TWO:   jsel = 3'd4;
      JK_WRIST_THREE: jsel = 3'd5;
      default:        jsel = 3'd0;
    endcase
    c = $signed(trig_in.c[jsel]);
    s = $signed(trig_in.s[jsel]);

    tr[0][0] = c;  tr[0][1] = -s; tr[0][2] = '0;
    tr[1][0] = s;  tr[1][1] = c;  tr[1][2] = '0;
    tr[2][0] = '0; tr[2][1] = '0; tr[2][2] = T_ONE;
    tp[0] = '0; tp[1] = '0; tp[2] = '0;
    case (kind)
      JK_SHOULDER: begin
        tr[1][0] = '0; tr[1][1] = '0; tr[1][2] = -T_ONE;
        tr[2][0] = s;  tr[2][1] = c;  tr[2][2] = '0;
      end
      JK_ELBOW: begin
        tp[0] = $signed(offs[REG_UPPER_ARM]);
        tp[2] = $signed(offs[REG_ELBOW_OFFSET]);
      end
      JK_WRIST_ONE: begin
        tp[0] = $signed(offs[REG_FOREARM]);
        tp[2] = $signed(offs[REG_WRIST_ONE]);
      end
      JK_WRIST_TWO: begin
        tr[1][0] = '0; tr[1][1] = '0; tr[1][2] = T_ONE;
        tr[2][0] = -s; tr[2][1] = -c; tr[2][2] = '0;
        tp[0] = $signed(offs[REG_WRIST_TWO]);
      end
      JK_WRIST_THREE: begin
        tp[0] = $signed(offs[REG_WRIST_THREE]);
        tp[2] = $signed(offs[REG_TOOL]);
      end
      default: begin
        tp[0] = '0;
      end
    endcase

    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        mr[i][k] = $signed(pose_in.r[i*3+k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < 3; j++) begin
            pr[i][j][k] <= mr[i][k] * tr[k][j];
          end
          pp[i][k] <= mr[i][k] * tp[k];
        end
      end
      mp_q   <= pose_in.p;
      trig_a <= trig_in;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sr[i][j] = SR_W'(pr[i][j][0]) + SR_W'(pr[i][j][1]) + SR_W'(pr[i][j][2]) + HALF_R;
        pose_next.r[i*3+j] = ROT_W'(sr[i][j] >>> FRAC_BITS);
      end
      sp[i] = SP_W'(pp[i][0]) + SP_W'(pp[i][1]) + SP_W'(pp[i][2]) + HALF_P;
      pose_next.p[i] = POS_W'(sp[i] >>> FRAC_BITS) + mp_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pose_out <= pose_next;
      trig_out <= trig_a;
    end
  end

endmodule

`default_nettype wire

/* rtl/six_joint_forward_kinematics_core.sv */
// Six-joint forward kinematics: six CORDIC lanes feed a five-link transform chain.
// Top level; depends on sjfk_pkg, sjfk_cordic_lane and sjfk_chain_stage.
//
// Usage:
//   Request channel in_valid/in_ready carries six binary joint angles.
//   Result channel out_valid/out_ready carries the 3x3 tool rotation and the
//   tool position, both with 16 fraction bits, clamped to their ranges.
//   Offsets are written through cfg_we/cfg_index/cfg_data while idle; this is
//   a rule for the user, as the core itself does not enforce it.
// Pipeline: 32 lane registers, the first loaded at the accepting edge, 2 per
//   link in the chain, and 1 output register that raises out_valid.
// Throughput: one request per cycle while in_ready is high; the rate is set
//   by the pipeline of the CORDIC lanes and the per-link multiplier stages,
//   each taking one pose per cycle.
// Reset: clears the pipeline valid bits and out_valid, loads default offsets.
// Stall: while out_ready is low the result holds; the pipeline keeps
//   advancing and taking requests until a finished pose reaches its last
//   stage, then in_ready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module six_joint_forward_kinematics_core import sjfk_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [IN_W-1:0]             joint1_angle,
  input  logic [IN_W-1:0]             joint2_angle,
  input  logic [IN_W-1:0]             joint3_angle,
  input  logic [IN_W-1:0]             joint4_angle,
  input  logic [IN_W-1:0]             joint5_angle,
  input  logic [IN_W-1:0]             joint6_angle,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_ROT_W-1:0] rot_00,
  output logic signed [OUT_ROT_W-1:0] rot_01,
  output logic signed [OUT_ROT_W-1:0] rot_02,
  output logic signed [OUT_ROT_W-1:0] rot_10,
  output logic signed [OUT_ROT_W-1:0] rot_11,
  output logic signed [OUT_ROT_W-1:0] rot_12,
  output logic signed [OUT_ROT_W-1:0] rot_20,
  output logic signed [OUT_ROT_W-1:0] rot_21,
  output logic signed [OUT_ROT_W-1:0] rot_22,
  output logic signed [OUT_POS_W-1:0] pos_x,
  output logic signed [OUT_POS_W-1:0] pos_y,
  output logic signed [OUT_POS_W-1:0] pos_z,
  input  logic                        cfg_we,
  input  logic [REG_IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]            cfg_data
);

  offs_t                  offs;
  logic [PIPE_DEPTH-1:0]  vpipe;
  logic                   en;
  logic                   out_load;
  logic [IN_W-1:0]        angles [JOINTS];
  trig_t                  trig [LINKS+1];
  pose_t                  pose [LINKS+1];

  assign en       = out_ready || !out_valid || !vpipe[PIPE_DEPTH-1];
  assign out_load = out_ready || !out_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      offs[REG_BASE_HEIGHT]  <= RST_BASE_HEIGHT;
      offs[REG_UPPER_ARM]    <= RST_UPPER_ARM;
      offs[REG_FOREARM]      <= RST_FOREARM;
      offs[REG_ELBOW_OFFSET] <= RST_ELBOW_OFFSET;
      offs[REG_WRIST_ONE]    <= RST_WRIST_ONE;
      offs[REG_WRIST_TWO]    <= RST_WRIST_TWO;
      offs[REG_WRIST_THREE]  <= RST_WRIST_THREE;
      offs[REG_TOOL]         <= RST_TOOL;
    end else if (cfg_we) begin
      offs[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[PIPE_DEPTH-2:0], in_valid};
    end
  end

  assign angles[0] = joint1_angle;
  assign angles[1] = joint2_angle;
  assign angles[2] = joint3_angle;
  assign angles[3] = joint4_angle;
  assign angles[4] = joint5_angle;
  assign angles[5] = joint6_angle;

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    sjfk_cordic_lane u_lane (
      .clk     (clk),
      .en      (en),
      .angle   (angles[j]),
      .cos_out (trig[0].c[j]),
      .sin_out (trig[0].s[j])
    );
  end

  always_comb begin
    pose[0].r[0] = ROT_W'($signed(trig[0].c[0]));
    pose[0].r[1] = -ROT_W'($signed(trig[0].s[0]));
    pose[0].r[2] = '0;
    pose[0].r[3] = ROT_W'($signed(trig[0].s[0]));
    pose[0].r[4] = ROT_W'($signed(trig[0].c[0]));
    pose[0].r[5] = '0;
    pose[0].r[6] = '0;
    pose[0].r[7] = '0;
    pose[0].r[8] = ROT_ONE;
    pose[0].p[0] = '0;
    pose[0].p[1] = '0;
    pose[0].p[2] = POS_W'($signed(offs[REG_BASE_HEIGHT]));
  end

  for (genvar k = 0; k < LINKS; k++) begin : g_link
    sjfk_chain_stage u_link (
      .clk      (clk),
      .en       (en),
      .kind     (LINK_KIND[k]),
      .pose_in  (pose[k]),
      .trig_in  (trig[k]),
      .offs     (offs),
      .pose_out (pose[k+1]),
      .trig_out (trig[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= vpipe[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rot_00 <= clamp_rot($signed(pose[LINKS].r[0]));
      rot_01 <= clamp_rot($signed(pose[LINKS].r[1]));
      rot_02 <= clamp_rot($signed(pose[LINKS].r[2]));
      rot_10 <= clamp_rot($signed(pose[LINKS].r[3]));
      rot_11 <= clamp_rot($signed(pose[LINKS].r[4]));
      rot_12 <= clamp_rot($signed(pose[LINKS].r[5]));
      rot_20 <= clamp_rot($signed(pose[LINKS].r[6]));
      rot_21 <= clamp_rot($signed(pose[LINKS].r[7]));
      rot_22 <= clamp_rot($signed(pose[LINKS].r[8]));
      pos_x  <= clamp_pos($signed(pose[LINKS].p[0]));
      pos_y  <= clamp_pos($signed(pose[LINKS].p[1]));
      pos_z  <= clamp_pos($signed(pose[LINKS].p[2]));
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && vpipe[PIPE_DEPTH-1]))
    else $error("request stalled while pipeline tail free");

  a_accept_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vpipe[0])
    else $error("accepted request missing from pipeline");

  a_result_from_tail: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(vpipe[PIPE_DEPTH-1]))
    else $error("result appeared without a finished pose");

endmodule

`default_nettype wire

/* tb/tb_six_joint_forward_kinematics_core.sv */
// Self-checking bench for six_joint_forward_kinematics_core: random and directed joint poses,
// a bit-exact pose predictor, offset register phases and random stalls on both channels.
// Depends on sjfk_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_six_joint_forward_kinematics_core;
  import sjfk_pkg::*;

  typedef struct {
    logic [IN_W-1:0] ang [JOINTS];
  } joints_t;

  typedef struct {
    logic signed [OUT_ROT_W-1:0] r [9];
    logic signed [OUT_POS_W-1:0] p [3];
  } tool_pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IN_W-1:0] joint1_angle = '0, joint2_angle = '0, joint3_angle = '0;
  logic [IN_W-1:0] joint4_angle = '0, joint5_angle = '0, joint6_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_ROT_W-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
  logic signed [OUT_ROT_W-1:0] rot_20, rot_21, rot_22;
  logic signed [OUT_POS_W-1:0] pos_x, pos_y, pos_z;
  logic cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  six_joint_forward_kinematics_core dut (.*);

  always #5 clk = ~clk;

  localparam longint ATAN_TAB [CORDIC_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };
  localparam longint UNIT = 64'sd1 << FRAC_BITS;

  longint offsets [REG_COUNT];
  joints_t pending_poses [$];
  tool_pose_t expected_poses [$];
  int mismatches = 0;

  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 << (sh - 1))) >>> sh;
  endfunction

  function automatic longint limit(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void joint_trig(input logic [IN_W-1:0] a, output longint co,
                                     output longint si);
    logic [31:0] th;
    bit flip;
    longint x, y, z, dx, dy;
    th = {a[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};
    flip = 1'b0;
    x = 64'sh26DD3B6A;
    y = 0;
    if (((th + 32'h40000000) & 32'h80000000) != 0) begin
      th = th - 32'h80000000;
      flip = 1'b1;
    end
    z = longint'(signed'(th));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    x = limit(round_shift(x, 30 - FRAC_BITS), -UNIT, UNIT);
    y = limit(round_shift(y, 30 - FRAC_BITS), -UNIT, UNIT);
    co = flip ? -x : x;
    si = flip ? -y : y;
  endfunction

  function automatic tool_pose_t predict_pose(joints_t q);
    longint c [6], s [6];
    longint mr [3][3], mp [3], tr [3][3], tp [3], nr [3][3], np [3];
    longint acc;
    tool_pose_t res;
    for (int j = 0; j < 6; j++) joint_trig(q.ang[j], c[j], s[j]);
    mr = '{'{c[0], -s[0], 0}, '{s[0], c[0], 0}, '{0, 0, UNIT}};
    mp = '{0, 0, offsets[REG_BASE_HEIGHT]};
    for (int j = 1; j < 6; j++) begin
      tr = '{'{c[j], -s[j], 0}, '{s[j], c[j], 0}, '{0, 0, UNIT}};
      tp = '{0, 0, 0};
      case (j)
        1: begin
          tr[1] = '{0, 0, -UNIT};
          tr[2] = '{s[j], c[j], 0};
        end
        2: tp = '{offsets[REG_UPPER_ARM], 0, offsets[REG_ELBOW_OFFSET]};
        3: tp = '{offsets[REG_FOREARM], 0, offsets[REG_WRIST_ONE]};
        4: begin
          tr[1] = '{0, 0, UNIT};
          tr[2] = '{-s[j], -c[j], 0};
          tp[0] = offsets[REG_WRIST_TWO];
        end
        default: tp = '{offsets[REG_WRIST_THREE], 0, offsets[REG_TOOL]};
      endcase
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          acc = 0;
          for (int m = 0; m < 3; m++) acc += mr[i][m] * tr[m][k];
          nr[i][k] = round_shift(acc, FRAC_BITS);
        end
        acc = 0;
        for (int m = 0; m < 3; m++) acc += mr[i][m] * tp[m];
        np[i] = round_shift(acc, FRAC_BITS) + mp[i];
      end
      mr = nr;
      mp = np;
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) res.r[i*3+k] = OUT_ROT_W'(limit(mr[i][k], -UNIT, UNIT));
      res.p[i] = OUT_POS_W'(limit(mp[i], -524288, 524287));
    end
    return res;
  endfunction

  // driver
  int send_wait = 0;
  bit send_free;
  always @(posedge clk) begin
    if (!rst) begin
      send_free = !in_valid;
      if (in_valid && in_ready) begin
        expected_poses.push_back(predict_pose(pending_poses.pop_front()));
        send_wait = $urandom_range(0, 8);
        send_free = 1'b1;
      end
      if (send_free) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_poses.size() > 0) begin
          joint1_angle <= pending_poses[0].ang[0];
          joint2_angle <= pending_poses[0].ang[1];
          joint3_angle <= pending_poses[0].ang[2];
          joint4_angle <= pending_poses[0].ang[3];
          joint5_angle <= pending_poses[0].ang[4];
          joint6_angle <= pending_poses[0].ang[5];
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int recv_wait = 0;
  always @(posedge clk) begin
    tool_pose_t want;
    logic signed [OUT_ROT_W-1:0] got_r [9];
    logic signed [OUT_POS_W-1:0] got_p [3];
    bit bad;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_r = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22};
        got_p = '{pos_x, pos_y, pos_z};
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          want = expected_poses.pop_front();
          bad = 1'b0;
          for (int i = 0; i < 9; i++) bad |= (got_r[i] !== want.r[i]);
          for (int i = 0; i < 3; i++) bad |= (got_p[i] !== want.p[i]);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: rot exp %p got %p", $realtime, want.r, got_r);
              $display("  pos exp %p got %p", want.p, got_p);
            end
          end
        end
        recv_wait = $urandom_range(0, 8);
        out_ready <= (recv_wait == 0);
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= (recv_wait == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_pose(int a1, int a2, int a3, int a4, int a5, int a6);
    joints_t q;
    q.ang = '{a1[15:0], a2[15:0], a3[15:0], a4[15:0], a5[15:0], a6[15:0]};
    pending_poses.push_back(q);
  endtask

  task automatic queue_random(int n);
    joints_t q;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < JOINTS; j++) begin
        case ($urandom_range(0, 5))
          0: q.ang[j] = 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
          default: q.ang[j] = 16'($urandom);
        endcase
      end
      pending_poses.push_back(q);
    end
  endtask

  task automatic drain;
    wait (pending_poses.size() == 0 && !in_valid && expected_poses.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_offset(reg_idx_t idx, longint val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= REG_W'(val);
    offsets[idx] = longint'(signed'(REG_W'(val)));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_offsets(int mode);
    for (int i = 0; i < REG_COUNT; i++) begin
      case (mode)
        0: write_offset(reg_idx_t'(i), 131071);
        1: write_offset(reg_idx_t'(i), -131072);
        2: write_offset(reg_idx_t'(i), (i % 2) ? -131072 : 131071);
        default: write_offset(reg_idx_t'(i), $urandom_range(0, 262143));
      endcase
    end
  endtask

  initial begin
    offsets = '{RST_BASE_HEIGHT, RST_UPPER_ARM, RST_FOREARM, RST_ELBOW_OFFSET,
                RST_WRIST_ONE, RST_WRIST_TWO, RST_WRIST_THREE, RST_TOOL};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // quadrant corners, extremes and the half-turn boundary
    queue_pose(0, 0, 0, 0, 0, 0);
    queue_pose(65535, 65535, 65535, 65535, 65535, 65535);
    queue_pose(16384, 16384, 16384, 16384, 16384, 16384);
    queue_pose(32768, 32768, 32768, 32768, 32768, 32768);
    queue_pose(49152, 49152, 49152, 49152, 49152, 49152);
    queue_pose(16383, 49151, 32767, 16385, 49153, 32769);
    queue_pose(21845, 43690, 4096, 61440, 8192, 57344);
    queue_pose(1, 2, 4, 8, 16, 32768);
    queue_random(10);
    drain();
    queue_random(250);
    drain();
    for (int mode = 0; mode < 4; mode++) begin
      load_offsets(mode);
      queue_pose(0, 0, 0, 0, 0, 0);
      queue_pose(8192, 8192, 8192, 8192, 8192, 8192);
      queue_pose(65535, 0, 65535, 0, 65535, 0);
      queue_random(200);
      drain();
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/sjfk_pkg.sv
rtl/sjfk_cordic_lane.sv
rtl/sjfk_chain_stage.sv
rtl/six_joint_forward_kinematics_core.sv
tb/tb_six_joint_forward_kinematics_core.sv
